// File: rtl/core/bvtc_pkg.sv
// shared constants and register indexes for the battery voltage core
package bvtc_pkg;

  localparam int ADC_W      = 12;
  localparam int GAIN_W     = 18;
  localparam int PT_W       = 10;
  localparam int CAL_W      = 60;
  localparam int MV_W       = 14;
  localparam int PT_SCALE   = 10;
  localparam int MV_MAX     = 16383;
  localparam int AVG_SHIFT  = 16;
  localparam int CFG_IDX_W  = 2;

  localparam int DIV_NUM_W  = 28;
  localparam int DIV_DEN_W  = 14;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MEASURED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_ACTUAL   = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RST     = 18'd132000;
  localparam logic [CAL_W-1:0]  MEASURED_RST = 60'd867702266203220440;
  localparam logic [CAL_W-1:0]  ACTUAL_RST   = 60'd845195286833306100;

endpackage

// File: rtl/core/bvtc_div.sv
// iterative restoring divider, one quotient bit per cycle
module bvtc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bvtc_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [bvtc_pkg::DIV_DEN_W-1:0] den_i,
  output logic                           done_o,
  output logic [bvtc_pkg::DIV_NUM_W-1:0] quot_o
);

  localparam int NW = bvtc_pkg::DIV_NUM_W;
  localparam int DW = bvtc_pkg::DIV_DEN_W;
  localparam int CW = bvtc_pkg::DIV_CNT_W;

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, den_q;
  logic [NW-1:0] nq_q;
  logic [DW:0]   shifted;
  logic          fits;

  assign shifted = {rem_q, nq_q[NW-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      nq_q  <= num_i;
    end else if (busy_q) begin
      rem_q <= fits ? DW'(shifted - {1'b0, den_q}) : shifted[DW-1:0];
      nq_q  <= {nq_q[NW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = nq_q;

endmodule

// File: rtl/core/battery_voltage_trimmed_calibrated_core.sv
// battery voltage core: trimmed burst mean, gain scaling and piecewise-linear calibration
//
// input channel: in_valid_i / in_ready_o with one adc_sample_i per item.
// zero samples are skipped; a burst closes on SAMPLES nonzero samples or
// MAX_ATTEMPTS items, empty slots counting as zero.
// an item that does not close a burst leaves the core idle and gives no result.
// an item that closes a burst starts the arithmetic sequence: trim, one multiply,
// one reciprocal multiply for the divide by SAMPLES-2, segment select, one multiply,
// one 28-step divide, fixup.
// a reading that needs no calibration divide skips the calibration multiply and the
// divide, going from segment select straight to fixup.
// in_ready_o is low during the sequence.
// output channel: out_valid_o / out_ready_i with voltage_mv_o, good_samples_o,
// short_burst_o held in an output register; samples of the next burst are taken
// while a result waits, and a closing burst holds in its last step until the
// output register is free. cfg_we_i writes cfg_wdata_i to register cfg_idx_i;
// the user must write only while idle, as the core does not check its state.
// reset clears the burst, empties the output and loads default calibration.
module battery_voltage_trimmed_calibrated_core #(
  parameter int SAMPLES      = 5,
  parameter int MAX_ATTEMPTS = 100,
  parameter int CAL_POINTS   = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bvtc_pkg::ADC_W-1:0]     adc_sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bvtc_pkg::MV_W-1:0]      voltage_mv_o,
  output logic [2:0]                     good_samples_o,
  output logic                           short_burst_o,
  input  logic                           cfg_we_i,
  input  logic [bvtc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bvtc_pkg::CAL_W-1:0]     cfg_wdata_i
);

  localparam int ADC_W  = bvtc_pkg::ADC_W;
  localparam int MV_W   = bvtc_pkg::MV_W;
  localparam int PT_W   = bvtc_pkg::PT_W;
  localparam int GAIN_W = bvtc_pkg::GAIN_W;
  localparam int NW     = bvtc_pkg::DIV_NUM_W;
  localparam int DW     = bvtc_pkg::DIV_DEN_W;
  localparam int CNT_W  = ($clog2(SAMPLES + 1) > 3) ? $clog2(SAMPLES + 1) : 3;
  localparam int ATT_W  = $clog2(MAX_ATTEMPTS + 1);
  localparam int SUM_W  = $clog2(SAMPLES * 4095 + 1);
  localparam int PROD_W = SUM_W + GAIN_W;
  localparam int LAST   = CAL_POINTS - 1;

  // divide by SAMPLES-2 as a multiply by a rounded-up reciprocal
  localparam int AVG_DIV = SAMPLES - 2;
  localparam int X_W     = PROD_W - bvtc_pkg::AVG_SHIFT;
  localparam int REC_SH  = X_W + 4;
  localparam int REC_W   = REC_SH + 1;
  localparam int MA_W    = (X_W > SUM_W) ? X_W : SUM_W;
  localparam int MB_W    = (REC_W > GAIN_W) ? REC_W : GAIN_W;
  localparam int MP_W    = MA_W + MB_W;
  localparam logic [REC_W-1:0] AVG_REC = REC_W'(((1 << REC_SH) + AVG_DIV - 1) / AVG_DIV);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_TRIM    = 10'b0000000010,
    ST_MUL_AVG = 10'b0000000100,
    ST_MUL_REC = 10'b0000001000,
    ST_LD_AVG  = 10'b0000010000,
    ST_SEG     = 10'b0000100000,
    ST_MUL_CAL = 10'b0001000000,
    ST_LD_CAL  = 10'b0010000000,
    ST_DIV_CAL = 10'b0100000000,
    ST_FIX     = 10'b1000000000
  } state_e;

  typedef enum logic [1:0] {
    K_DIRECT,
    K_SCALE,
    K_ADD,
    K_SUB
  } cal_kind_e;

  state_e state_q, state_d;

  logic [GAIN_W-1:0]              gain_q;
  logic [bvtc_pkg::CAL_W-1:0]     meas_q, act_q;

  logic [CNT_W-1:0] good_q, good_nx;
  logic [ATT_W-1:0] att_q, att_nx;
  logic [SUM_W-1:0] sum_q, mid_q;
  logic [ADC_W-1:0] min_q, max_q;
  logic             short_q;
  logic [2:0]       gout_q;

  logic             in_acc, fill, close;

  logic [MA_W-1:0]   op_a;
  logic [MB_W-1:0]   op_b;
  logic [MP_W-1:0]   prod_q;

  logic              div_start, div_done;
  logic [NW-1:0]     div_num, quot;
  logic [DW-1:0]     div_den;

  logic [MV_W-1:0]   mv_q;
  logic [MV_W-1:0]   m_pt [CAL_POINTS];
  logic [MV_W-1:0]   a_pt [CAL_POINTS];

  cal_kind_e         kind_q, kind_d;
  logic [MV_W-1:0]   base_q, base_d, mula_q, mula_d, mulb_q, mulb_d, den_q, den_d;
  logic              found;
  logic [MV_W-1:0]   mi, mn, ai, an;

  logic [NW:0]       fix_r;
  logic [MV_W-1:0]   fix_sat;
  logic              out_load;

  logic              out_valid_q;
  logic [MV_W-1:0]   mv_out_q;
  logic [2:0]        good_out_q;
  logic              short_out_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= bvtc_pkg::GAIN_RST;
      meas_q <= bvtc_pkg::MEASURED_RST;
      act_q  <= bvtc_pkg::ACTUAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bvtc_pkg::REG_DIVIDER_GAIN: gain_q <= cfg_wdata_i[GAIN_W-1:0];
        bvtc_pkg::REG_CAL_MEASURED: meas_q <= cfg_wdata_i;
        bvtc_pkg::REG_CAL_ACTUAL:   act_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // burst gathering
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign fill       = (adc_sample_i != '0) && (good_q < CNT_W'(SAMPLES));
  assign good_nx    = good_q + CNT_W'(fill);
  assign att_nx     = att_q + 1'b1;
  assign close      = (good_nx == CNT_W'(SAMPLES)) || (att_nx == ATT_W'(MAX_ATTEMPTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_q <= '0;
      att_q  <= '0;
      sum_q  <= '0;
      min_q  <= '1;
      max_q  <= '0;
    end else if (in_acc) begin
      good_q <= good_nx;
      att_q  <= att_nx;
      if (fill) begin
        sum_q <= sum_q + SUM_W'(adc_sample_i);
        if (adc_sample_i < min_q) begin
          min_q <= adc_sample_i;
        end
        if (adc_sample_i > max_q) begin
          max_q <= adc_sample_i;
        end
      end
    end else if (state_q == ST_TRIM) begin
      good_q <= '0;
      att_q  <= '0;
      sum_q  <= '0;
      min_q  <= '1;
      max_q  <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && close) begin
      short_q <= (good_nx != CNT_W'(SAMPLES));
      gout_q  <= good_nx[2:0];
    end
    if (state_q == ST_TRIM) begin
      mid_q <= sum_q - (short_q ? SUM_W'(0) : SUM_W'(min_q)) - SUM_W'(max_q);
    end
  end

  // shared multiplier
  always_comb begin
    if (state_q == ST_MUL_AVG) begin
      op_a = MA_W'(mid_q);
      op_b = MB_W'(gain_q);
    end else if (state_q == ST_MUL_REC) begin
      op_a = MA_W'(prod_q[PROD_W-1:bvtc_pkg::AVG_SHIFT]);
      op_b = MB_W'(AVG_REC);
    end else begin
      op_a = MA_W'(mula_q);
      op_b = MB_W'(mulb_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL_AVG || state_q == ST_MUL_REC || state_q == ST_MUL_CAL) begin
      prod_q <= MP_W'(op_a) * MP_W'(op_b);
    end
  end

  // serial divider for the calibration divide
  assign div_start = (state_q == ST_LD_CAL);
  assign div_num   = prod_q[NW-1:0];
  assign div_den   = den_q;

  bvtc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LD_AVG) begin
      mv_q <= prod_q[REC_SH +: MV_W];
    end
  end

  // calibration segment select
  always_comb begin
    for (int k = 0; k < CAL_POINTS; k++) begin
      m_pt[k] = MV_W'(meas_q[PT_W*k +: PT_W]) * MV_W'(bvtc_pkg::PT_SCALE);
      a_pt[k] = MV_W'(act_q[PT_W*k +: PT_W]) * MV_W'(bvtc_pkg::PT_SCALE);
    end
  end

  always_comb begin
    found = 1'b0;
    mi    = m_pt[0];
    mn    = m_pt[1];
    ai    = a_pt[0];
    an    = a_pt[1];
    for (int i = 0; i < LAST; i++) begin
      if (!found && m_pt[i+1] > mv_q) begin
        found = 1'b1;
        mi    = m_pt[i];
        mn    = m_pt[i+1];
        ai    = a_pt[i];
        an    = a_pt[i+1];
      end
    end
  end

  always_comb begin
    kind_d = K_DIRECT;
    base_d = a_pt[LAST];
    mula_d = mv_q;
    mulb_d = a_pt[0];
    den_d  = m_pt[0];
    priority if (mv_q < m_pt[0]) begin
      kind_d = K_SCALE;
    end else if (mv_q > m_pt[LAST]) begin
      if (m_pt[LAST] == '0) begin
        base_d = mv_q;
      end else begin
        kind_d = K_SCALE;
        mulb_d = a_pt[LAST];
        den_d  = m_pt[LAST];
      end
    end else if (found) begin
      base_d = ai;
      mula_d = mv_q - mi;
      den_d  = mn - mi;
      if (an >= ai) begin
        kind_d = K_ADD;
        mulb_d = an - ai;
      end else begin
        kind_d = K_SUB;
        mulb_d = ai - an;
      end
    end else begin
      kind_d = K_DIRECT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SEG) begin
      kind_q <= kind_d;
      base_q <= base_d;
      mula_q <= mula_d;
      mulb_q <= mulb_d;
      den_q  <= den_d;
    end
  end

  // final fixup and saturation
  always_comb begin
    unique case (kind_q)
      K_DIRECT: fix_r = (NW+1)'(base_q);
      K_SCALE:  fix_r = (NW+1)'(quot);
      K_ADD:    fix_r = (NW+1)'(base_q) + (NW+1)'(quot);
      K_SUB:    fix_r = (quot > NW'(base_q)) ? '0 : (NW+1)'(base_q) - (NW+1)'(quot);
      default:  fix_r = '0;
    endcase
    fix_sat = (fix_r > (NW+1)'(bvtc_pkg::MV_MAX)) ? MV_W'(bvtc_pkg::MV_MAX) : fix_r[MV_W-1:0];
  end

  assign out_load = (state_q == ST_FIX) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_acc && close) state_d = ST_TRIM;
      ST_TRIM:    state_d = ST_MUL_AVG;
      ST_MUL_AVG: state_d = ST_MUL_REC;
      ST_MUL_REC: state_d = ST_LD_AVG;
      ST_LD_AVG:  state_d = ST_SEG;
      ST_SEG:     state_d = (kind_d == K_DIRECT) ? ST_FIX : ST_MUL_CAL;
      ST_MUL_CAL: state_d = ST_LD_CAL;
      ST_LD_CAL:  state_d = ST_DIV_CAL;
      ST_DIV_CAL: if (div_done) state_d = ST_FIX;
      ST_FIX:     if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mv_out_q    <= fix_sat;
      good_out_q  <= gout_q;
      short_out_q <= short_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign voltage_mv_o   = mv_out_q;
  assign good_samples_o = good_out_q;
  assign short_burst_o  = short_out_q;

endmodule
